// ===== rtl/core/sdf_pkg.sv =====
// ----------------------------------------------------------------------------
// Serial message deframer package
// Shared request/result types, opcode and status codes, default parameters.
// ----------------------------------------------------------------------------
package sdf_pkg;

  // default sizing of the header checks
  localparam int unsigned MaxLenDefault   = 256;
  localparam int unsigned NumTypesDefault = 4;

  localparam int unsigned LenW  = 14;
  localparam int unsigned FldW  = 7;
  localparam int unsigned TickW = 32;

  localparam logic [7:0] StartByte = 8'hA5;

  // request opcodes
  localparam logic OpByte = 1'b0;
  localparam logic OpTick = 1'b1;

  // closing status codes
  localparam logic [2:0] StOk     = 3'd0;
  localparam logic [2:0] StHuntTo = 3'd1;
  localparam logic [2:0] StMsgTo  = 3'd2;
  localparam logic [2:0] StBadHdr = 3'd3;
  localparam logic [2:0] StBadSum = 3'd4;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } sdf_req_t;

  typedef struct packed {
    logic            byte_valid;
    logic [7:0]      data_byte;
    logic            last;
    logic [2:0]      status;
    logic [FldW-1:0] msg_type;
    logic [FldW-1:0] msg_number;
    logic [LenW-1:0] msg_length;
  } sdf_res_t;

endpackage

// ===== rtl/core/sdf_in_stage.sv =====
// ----------------------------------------------------------------------------
// Deframer input register
// Holds one request until the core consumes it; refills in the same cycle.
// ----------------------------------------------------------------------------
module sdf_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sdf_pkg::sdf_req_t in_req_i,
  input  logic              advance_i,
  output logic              req_valid_o,
  output sdf_pkg::sdf_req_t req_o
);
  import sdf_pkg::*;

  logic     valid_q, valid_d;
  sdf_req_t req_q;

  assign in_ready_o  = !valid_q || advance_i;
  assign valid_d     = (in_valid_i && in_ready_o) || (valid_q && !advance_i);
  assign req_valid_o = valid_q;
  assign req_o       = req_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= in_req_i;
    end
  end

endmodule

// ===== rtl/core/sdf_core.sv =====
// ----------------------------------------------------------------------------
// Deframer core
// Framing state machine: hunt, header, payload, checksum and tick budget.
// ----------------------------------------------------------------------------
module sdf_core #(
  parameter int unsigned MaxLen   = sdf_pkg::MaxLenDefault,
  parameter int unsigned NumTypes = sdf_pkg::NumTypesDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     step_i,
  input  sdf_pkg::sdf_req_t        req_i,
  input  logic [sdf_pkg::TickW-1:0] timeout_i,
  output logic                     has_res_o,
  output sdf_pkg::sdf_res_t        res_o
);
  import sdf_pkg::*;

  localparam logic [LenW-1:0] MaxLenC   = LenW'(MaxLen);
  localparam logic [FldW:0]   NumTypesC = (FldW + 1)'(NumTypes);

  typedef enum logic [1:0] {
    PhHunt,
    PhHead,
    PhData
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [2:0]      hidx_q, hidx_d;
  logic [FldW-1:0] exp_q, exp_d;
  logic [FldW-1:0] type_q, type_d;
  logic [FldW-1:0] num_q, num_d;
  logic [LenW-1:0] len_q, len_d;
  logic [LenW-1:0] seen_q, seen_d;
  logic [FldW-1:0] sum_q, sum_d;
  logic [TickW-1:0] tick_q, tick_d;

  logic [FldW-1:0]  v7;
  logic [FldW-1:0]  hdr_sum;
  logic [FldW-1:0]  pay_sum;
  logic [LenW-1:0]  seen_inc;
  logic [TickW-1:0] tick_inc;

  assign v7       = req_i.rx_byte[FldW-1:0];
  assign hdr_sum  = len_q[FldW-1:0] + len_q[LenW-1:FldW] + type_q + v7;
  assign pay_sum  = sum_q + v7;
  assign seen_inc = seen_q + LenW'(1);
  assign tick_inc = tick_q + TickW'(1);

  always_comb begin
    phase_d   = phase_q;
    hidx_d    = hidx_q;
    exp_d     = exp_q;
    type_d    = type_q;
    num_d     = num_q;
    len_d     = len_q;
    seen_d    = seen_q;
    sum_d     = sum_q;
    tick_d    = tick_q;
    has_res_o = 1'b0;
    res_o     = '0;

    if (req_i.op == OpTick) begin
      if (timeout_i != '0) begin
        tick_d = tick_inc;
        if (tick_inc >= timeout_i) begin
          has_res_o = 1'b1;
          res_o.last = 1'b1;
          if (phase_q == PhHunt) begin
            res_o.status = StHuntTo;
          end else begin
            res_o.status     = StMsgTo;
            res_o.msg_type   = type_q;
            res_o.msg_number = num_q;
            res_o.msg_length = len_q;
          end
          phase_d = PhHunt;
          hidx_d  = '0;
          tick_d  = '0;
        end
      end
    end else begin
      unique case (phase_q)
        PhHunt: begin
          if (req_i.rx_byte == StartByte) begin
            phase_d = PhHead;
            hidx_d  = '0;
            exp_d   = '0;
            type_d  = '0;
            num_d   = '0;
            len_d   = '0;
            seen_d  = '0;
            sum_d   = '0;
          end
        end
        PhHead: begin
          hidx_d = hidx_q + 3'd1;
          unique case (hidx_q)
            3'd0: exp_d = v7;
            3'd1: len_d = {v7, FldW'(0)};
            3'd2: len_d = {len_q[LenW-1:FldW], v7};
            3'd3: type_d = v7;
            default: begin
              num_d            = v7;
              has_res_o        = 1'b1;
              res_o.last       = 1'b1;
              res_o.msg_type   = type_q;
              res_o.msg_number = v7;
              res_o.msg_length = len_q;
              seen_d           = '0;
              if ({1'b0, type_q} >= NumTypesC || len_q > MaxLenC) begin
                res_o.status = StBadHdr;
                phase_d      = PhHunt;
                hidx_d       = '0;
                tick_d       = '0;
              end else begin
                sum_d = hdr_sum;
                if (len_q == '0) begin
                  res_o.status = (hdr_sum == exp_q) ? StOk : StBadSum;
                  phase_d      = PhHunt;
                  hidx_d       = '0;
                  tick_d       = '0;
                end else begin
                  has_res_o  = 1'b0;
                  res_o.last = 1'b0;
                  phase_d    = PhData;
                end
              end
            end
          endcase
        end
        default: begin
          // payload byte
          sum_d            = pay_sum;
          seen_d           = seen_inc;
          has_res_o        = 1'b1;
          res_o.byte_valid = 1'b1;
          res_o.data_byte  = req_i.rx_byte;
          res_o.msg_type   = type_q;
          res_o.msg_number = num_q;
          res_o.msg_length = len_q;
          if (seen_inc >= len_q) begin
            res_o.last   = 1'b1;
            res_o.status = (pay_sum == exp_q) ? StOk : StBadSum;
            phase_d      = PhHunt;
            hidx_d       = '0;
            tick_d       = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      hidx_q  <= '0;
      exp_q   <= '0;
      type_q  <= '0;
      num_q   <= '0;
      len_q   <= '0;
      seen_q  <= '0;
      sum_q   <= '0;
      tick_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      hidx_q  <= hidx_d;
      exp_q   <= exp_d;
      type_q  <= type_d;
      num_q   <= num_d;
      len_q   <= len_d;
      seen_q  <= seen_d;
      sum_q   <= sum_d;
      tick_q  <= tick_d;
    end
  end

endmodule

// ===== rtl/core/sdf_out_stage.sv =====
// ----------------------------------------------------------------------------
// Deframer result register
// Holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module sdf_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  sdf_pkg::sdf_res_t res_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sdf_pkg::sdf_res_t out_res_o
);
  import sdf_pkg::*;

  logic     valid_q, valid_d;
  sdf_res_t res_q;

  assign free_o      = !valid_q || out_ready_i;
  assign valid_d     = load_i || (valid_q && !out_ready_i);
  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

// ===== rtl/core/serial_message_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// Serial message deframer
// Receive side of a start-byte / length / checksum framing.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o, in_req_i) carries one request per
//   handshake: a received byte (op = byte) or one timer tick (op = tick).
//   Output channel (out_valid_o/out_ready_i, out_res_o) carries payload bytes
//   and closing status words; a request yields zero or one result.
//   Config: cfg_we_i writes cfg_wdata_i into the tick budget (0 = no timeout).
//   Order: a request is registered in the input register, then its result,
//   if any, is loaded into the result register once that register is free.
//   Throughput: 1 request per cycle while the result register is free; the
//   core's state update between the input and result registers holds while
//   a result is pending.
//   Reset: hunting for the start byte, tick budget 0, both registers empty.
//   Stall: when the receiver holds out_ready_i low with a result pending, the
//   core holds; the input register takes one more request if it is empty,
//   then in_ready_o drops until the result is taken.
// ----------------------------------------------------------------------------
module serial_message_deframer_unit #(
  parameter int unsigned MaxLen   = sdf_pkg::MaxLenDefault,
  parameter int unsigned NumTypes = sdf_pkg::NumTypesDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  sdf_pkg::sdf_req_t         in_req_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output sdf_pkg::sdf_res_t         out_res_o,
  input  logic                      cfg_we_i,
  input  logic [sdf_pkg::TickW-1:0] cfg_wdata_i
);
  import sdf_pkg::*;

  logic             req_valid;
  sdf_req_t         req;
  logic             out_free;
  logic             advance;
  logic             has_res;
  sdf_res_t         res;
  logic [TickW-1:0] timeout_q;

  // advance the held request only when the result register can take a result
  assign advance = req_valid && out_free;

  // tick budget register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= '0;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  sdf_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .advance_i   (advance),
    .req_valid_o (req_valid),
    .req_o       (req)
  );

  sdf_core #(
    .MaxLen   (MaxLen),
    .NumTypes (NumTypes)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .req_i     (req),
    .timeout_i (timeout_q),
    .has_res_o (has_res),
    .res_o     (res)
  );

  // load only requests that produce a result; drop the rest
  sdf_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && has_res),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res_o)
  );

endmodule
